### design/arc_pkg.sv
// Shared types, codes and defaults for the ARP resolution cache.
package arc_pkg;

    localparam int TABLE_ENTRIES_DEF  = 16;
    localparam int HELD_PER_ENTRY_DEF = 4;

    localparam int MAC_W  = 48;
    localparam int IP_W   = 32;
    localparam int TAG_W  = 16;
    localparam int TIME_W = 64;
    localparam int MS_W   = 32;
    localparam int CFG_W  = 48;
    localparam int CIDX_W = 2;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] OP_REQUEST = 16'd1;
    localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

    localparam logic [MS_W-1:0] TIMEOUT_RST = 32'd30000;
    localparam logic [MS_W-1:0] HOLD_RST    = 32'd5000;

    typedef enum logic [CIDX_W-1:0] {
        REG_LOCAL_MAC = 2'd0,
        REG_LOCAL_IP  = 2'd1,
        REG_TIMEOUT   = 2'd2,
        REG_HOLD      = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_SEND = 2'd0,
        MODE_RECV = 2'd1,
        MODE_TICK = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_FWD   = 3'd0,
        KIND_REQ   = 3'd1,
        KIND_REPLY = 3'd2,
        KIND_UP    = 3'd3,
        KIND_DROP  = 3'd4,
        KIND_BAD   = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        SEL_FWD_SEND,
        SEL_FWD_HELD,
        SEL_REQ,
        SEL_DROP,
        SEL_UP,
        SEL_BAD,
        SEL_REPLY
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      scan_start;
        logic      scan_step;
        logic      tick_start;
        logic      tick_step;
        logic      pick;
        logic      set_req;
        logic      hold_push;
        logic      learn;
        logic      rel_rd;
        logic      rel_next;
        logic      clr_count;
        logic      emit;
        emit_sel_t sel;
        logic      last;
    } ctrl_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  scan_last;
        logic  slot_ok;
        logic  ent_mapped;
        logic  ent_active;
        logic  ent_full;
        logic  rel_done;
        logic  rel_final;
        logic  mac_ok;
        logic  is_ipv4;
        logic  is_arp;
        logic  tip_ok;
        logic  is_request;
        logic  out_free;
    } dp_stat_t;

endpackage

### design/arc_ram.sv
// Generic single-port-write, registered-read RAM.
module arc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/arc_ctrl.sv
// Event sequencer: steps each event through search, update, release and reply.
module arc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  arc_pkg::dp_stat_t  stat,
    output arc_pkg::ctrl_cmd_t cmd
);
    import arc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_PICK,
        ST_SEND_ACT,
        ST_SEND_Q,
        ST_DROP,
        ST_LEARN,
        ST_REL_CHK,
        ST_REL_EMIT,
        ST_REPLY,
        ST_SWEEP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.sel    = SEL_BAD;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (stat.mode)
                    MODE_SEND:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    MODE_TICK:
                    begin
                        cmd.tick_start = 1'b1;
                        state_next     = ST_SWEEP;
                    end
                    MODE_NOP:
                    begin
                        state_next = ST_IDLE;
                    end
                    MODE_RECV:
                    begin
                        priority if (!stat.mac_ok)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (stat.is_ipv4 || !stat.is_arp)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.sel    = stat.is_ipv4 ? SEL_UP : SEL_BAD;
                                cmd.last   = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        else if (!stat.tip_ok)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                cmd.pick = 1'b1;
                priority if (!stat.slot_ok)
                begin
                    state_next = (stat.mode == MODE_SEND) ? ST_DROP : ST_REPLY;
                end
                else if (stat.mode == MODE_SEND)
                begin
                    state_next = ST_SEND_ACT;
                end
                else
                begin
                    state_next = ST_LEARN;
                end
            end
            ST_SEND_ACT:
            begin
                priority if (stat.ent_mapped)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.sel    = SEL_FWD_SEND;
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (!stat.ent_active)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.sel     = SEL_REQ;
                        cmd.last    = !stat.ent_full;
                        cmd.set_req = 1'b1;
                        state_next  = ST_SEND_Q;
                    end
                end
                else
                begin
                    state_next = ST_SEND_Q;
                end
            end
            ST_SEND_Q:
            begin
                if (!stat.ent_full)
                begin
                    cmd.hold_push = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DROP;
                end
            end
            ST_DROP:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_DROP;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LEARN:
            begin
                // mapped entries are not refreshed
                if (stat.ent_mapped)
                begin
                    state_next = ST_REPLY;
                end
                else
                begin
                    cmd.learn  = 1'b1;
                    state_next = ST_REL_CHK;
                end
            end
            ST_REL_CHK:
            begin
                if (stat.rel_done)
                begin
                    cmd.clr_count = 1'b1;
                    state_next    = ST_REPLY;
                end
                else
                begin
                    cmd.rel_rd = 1'b1;
                    state_next = ST_REL_EMIT;
                end
            end
            ST_REL_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.sel      = SEL_FWD_HELD;
                    cmd.last     = stat.rel_final && !stat.is_request;
                    cmd.rel_next = 1'b1;
                    state_next   = ST_REL_CHK;
                end
            end
            ST_REPLY:
            begin
                if (!stat.is_request)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_REPLY;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                cmd.tick_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### design/arc_dp.sv
// Datapath: event registers, entry table, held-datagram queue and result register.
module arc_dp #(
    parameter int TABLE_ENTRIES  = arc_pkg::TABLE_ENTRIES_DEF,
    parameter int HELD_PER_ENTRY = arc_pkg::HELD_PER_ENTRY_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  arc_pkg::ctrl_cmd_t                   cmd,
    output arc_pkg::dp_stat_t                    stat,
    input  logic                                 cfg_valid,
    input  logic [arc_pkg::CIDX_W-1:0]           cfg_index,
    input  logic [arc_pkg::CFG_W-1:0]            cfg_data,
    input  logic [1:0]                           mode,
    input  logic [arc_pkg::IP_W-1:0]             next_hop_ip,
    input  logic [arc_pkg::TAG_W-1:0]            payload_tag,
    input  logic [arc_pkg::MAC_W-1:0]            frame_dst_mac,
    input  logic [15:0]                          frame_ethertype,
    input  logic [15:0]                          arp_opcode,
    input  logic [arc_pkg::IP_W-1:0]             arp_sender_ip,
    input  logic [arc_pkg::MAC_W-1:0]            arp_sender_mac,
    input  logic [arc_pkg::IP_W-1:0]             arp_target_ip,
    input  logic [15:0]                          elapsed_ms,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [2:0]                           out_kind,
    output logic [arc_pkg::MAC_W-1:0]            out_dst_mac,
    output logic [arc_pkg::IP_W-1:0]             out_target_ip,
    output logic [arc_pkg::TAG_W-1:0]            out_tag,
    output logic                                 out_last
);
    import arc_pkg::*;

    localparam int EW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW    = $clog2(HELD_PER_ENTRY + 1);
    localparam int HDEP  = TABLE_ENTRIES * HELD_PER_ENTRY;
    localparam int HAW   = (HDEP > 1) ? $clog2(HDEP) : 1;
    localparam logic [EW-1:0] LAST_IDX = EW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] HELD_MAX = CW'(HELD_PER_ENTRY);

    // configuration
    logic [MAC_W-1:0] local_mac_reg;
    logic [IP_W-1:0]  local_ip_reg;
    logic [MS_W-1:0]  timeout_reg;
    logic [MS_W-1:0]  hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_mac_reg <= '0;
            local_ip_reg  <= '0;
            timeout_reg   <= TIMEOUT_RST;
            hold_reg      <= HOLD_RST;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_LOCAL_MAC: local_mac_reg <= cfg_data;
                REG_LOCAL_IP:  local_ip_reg  <= cfg_data[IP_W-1:0];
                REG_TIMEOUT:   timeout_reg   <= cfg_data[MS_W-1:0];
                REG_HOLD:      hold_reg      <= cfg_data[MS_W-1:0];
                default: ;
            endcase
        end
    end

    // event registers
    mode_t            mode_reg;
    logic [IP_W-1:0]  key_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [MAC_W-1:0] smac_reg;
    logic [15:0]      elapsed_reg;
    logic             mac_ok_reg;
    logic             ipv4_reg;
    logic             arp_reg;
    logic             tip_ok_reg;
    logic             req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NOP;
        end
        else if (cmd.load)
        begin
            mode_reg <= mode_t'(mode);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg     <= (mode_t'(mode) == MODE_SEND) ? next_hop_ip : arp_sender_ip;
            tag_reg     <= payload_tag;
            smac_reg    <= arp_sender_mac;
            elapsed_reg <= elapsed_ms;
            mac_ok_reg  <= (frame_dst_mac == local_mac_reg) || (frame_dst_mac == MAC_BCAST);
            ipv4_reg    <= (frame_ethertype == ETYPE_IPV4);
            arp_reg     <= (frame_ethertype == ETYPE_ARP);
            tip_ok_reg  <= (arp_target_ip == local_ip_reg);
            req_reg     <= (arp_opcode == OP_REQUEST);
        end
    end

    // entry table
    logic              used_reg   [TABLE_ENTRIES];
    logic              mapped_reg [TABLE_ENTRIES];
    logic              active_reg [TABLE_ENTRIES];
    logic [CW-1:0]     count_reg  [TABLE_ENTRIES];
    logic [IP_W-1:0]   ip_reg     [TABLE_ENTRIES];
    logic [MAC_W-1:0]  mac_reg    [TABLE_ENTRIES];
    logic [TIME_W-1:0] learn_reg  [TABLE_ENTRIES];
    logic [TIME_W-1:0] rtime_reg  [TABLE_ENTRIES];

    logic [TIME_W-1:0] now_reg;
    logic [EW-1:0]     cnt_reg;
    logic              found_reg;
    logic              free_ok_reg;
    logic [EW-1:0]     match_reg;
    logic [EW-1:0]     free_reg;
    logic [EW-1:0]     e_reg;
    logic              ent_mapped_reg;
    logic              ent_active_reg;
    logic [CW-1:0]     ent_count_reg;
    logic [MAC_W-1:0]  ent_mac_reg;
    logic [CW-1:0]     k_reg;

    logic              hit;
    logic              exp_map;
    logic              exp_req;
    logic              new_mapped;
    logic              new_active;

    assign hit = used_reg[cnt_reg] && (ip_reg[cnt_reg] == key_reg);
    assign exp_map = (now_reg - learn_reg[cnt_reg]) >= {{(TIME_W-MS_W){1'b0}}, timeout_reg};
    assign exp_req = (now_reg - rtime_reg[cnt_reg]) >= {{(TIME_W-MS_W){1'b0}}, hold_reg};
    assign new_mapped = mapped_reg[cnt_reg] && !exp_map;
    assign new_active = active_reg[cnt_reg] && !exp_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg     <= '0;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            free_ok_reg <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                used_reg[i]   <= 1'b0;
                mapped_reg[i] <= 1'b0;
                active_reg[i] <= 1'b0;
                count_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.scan_start)
            begin
                cnt_reg     <= '0;
                found_reg   <= 1'b0;
                free_ok_reg <= 1'b0;
            end
            if (cmd.tick_start)
            begin
                cnt_reg <= '0;
                now_reg <= now_reg + {{(TIME_W-16){1'b0}}, elapsed_reg};
            end
            if (cmd.scan_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (hit && !found_reg)
                begin
                    found_reg <= 1'b1;
                end
                if (!used_reg[cnt_reg] && !free_ok_reg)
                begin
                    free_ok_reg <= 1'b1;
                end
            end
            if (cmd.tick_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (used_reg[cnt_reg])
                begin
                    mapped_reg[cnt_reg] <= new_mapped;
                    active_reg[cnt_reg] <= new_active;
                    if (!new_mapped && !new_active && count_reg[cnt_reg] == '0)
                    begin
                        used_reg[cnt_reg] <= 1'b0;
                    end
                end
            end
            if (cmd.pick && !found_reg && free_ok_reg)
            begin
                used_reg[free_reg]   <= 1'b1;
                mapped_reg[free_reg] <= 1'b0;
                active_reg[free_reg] <= 1'b0;
                count_reg[free_reg]  <= '0;
            end
            if (cmd.set_req)
            begin
                active_reg[e_reg] <= 1'b1;
            end
            if (cmd.hold_push)
            begin
                count_reg[e_reg] <= ent_count_reg + 1'b1;
            end
            if (cmd.learn)
            begin
                mapped_reg[e_reg] <= 1'b1;
            end
            if (cmd.clr_count)
            begin
                count_reg[e_reg] <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            if (hit && !found_reg)
            begin
                match_reg      <= cnt_reg;
                ent_mapped_reg <= mapped_reg[cnt_reg];
                ent_active_reg <= active_reg[cnt_reg];
                ent_count_reg  <= count_reg[cnt_reg];
                ent_mac_reg    <= mac_reg[cnt_reg];
            end
            if (!used_reg[cnt_reg] && !free_ok_reg)
            begin
                free_reg <= cnt_reg;
            end
        end
        if (cmd.pick)
        begin
            if (found_reg)
            begin
                e_reg <= match_reg;
            end
            else if (free_ok_reg)
            begin
                e_reg          <= free_reg;
                ip_reg[free_reg] <= key_reg;
                ent_mapped_reg <= 1'b0;
                ent_active_reg <= 1'b0;
                ent_count_reg  <= '0;
            end
        end
        if (cmd.set_req)
        begin
            rtime_reg[e_reg] <= now_reg;
            ent_active_reg   <= 1'b1;
        end
        if (cmd.learn)
        begin
            mac_reg[e_reg]   <= smac_reg;
            learn_reg[e_reg] <= now_reg;
            k_reg            <= '0;
        end
        if (cmd.rel_next)
        begin
            k_reg <= k_reg + 1'b1;
        end
    end

    // held-datagram queue, one row of slots per entry
    logic [HAW-1:0]   held_wr_addr;
    logic [HAW-1:0]   held_rd_addr;
    logic [TAG_W-1:0] held_rd_data;

    assign held_wr_addr = HAW'(int'(e_reg) * HELD_PER_ENTRY + int'(ent_count_reg));
    assign held_rd_addr = HAW'(int'(e_reg) * HELD_PER_ENTRY + int'(k_reg));

    arc_ram #(
        .WIDTH (TAG_W),
        .DEPTH (HDEP)
    ) u_held (
        .clk     (clk),
        .wr_en   (cmd.hold_push),
        .wr_addr (held_wr_addr),
        .wr_data (tag_reg),
        .rd_en   (cmd.rel_rd),
        .rd_addr (held_rd_addr),
        .rd_data (held_rd_data)
    );

    // result register
    logic             out_valid_reg;
    kind_t            kind_reg;
    logic [MAC_W-1:0] omac_reg;
    logic [IP_W-1:0]  oip_reg;
    logic [TAG_W-1:0] otag_reg;
    logic             olast_reg;
    kind_t            kind_next;
    logic [MAC_W-1:0] omac_next;
    logic [IP_W-1:0]  oip_next;
    logic [TAG_W-1:0] otag_next;

    always_comb
    begin
        kind_next = KIND_BAD;
        omac_next = '0;
        oip_next  = '0;
        otag_next = '0;
        unique case (cmd.sel)
            SEL_FWD_SEND:
            begin
                kind_next = KIND_FWD;
                omac_next = ent_mac_reg;
                otag_next = tag_reg;
            end
            SEL_FWD_HELD:
            begin
                kind_next = KIND_FWD;
                omac_next = smac_reg;
                otag_next = held_rd_data;
            end
            SEL_REQ:
            begin
                kind_next = KIND_REQ;
                omac_next = MAC_BCAST;
                oip_next  = key_reg;
            end
            SEL_DROP:
            begin
                kind_next = KIND_DROP;
                oip_next  = key_reg;
                otag_next = tag_reg;
            end
            SEL_UP:
            begin
                kind_next = KIND_UP;
                otag_next = tag_reg;
            end
            SEL_BAD:
            begin
                kind_next = KIND_BAD;
            end
            SEL_REPLY:
            begin
                kind_next = KIND_REPLY;
                omac_next = smac_reg;
                oip_next  = key_reg;
            end
            default: kind_next = KIND_BAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg  <= kind_next;
            omac_reg  <= omac_next;
            oip_reg   <= oip_next;
            otag_reg  <= otag_next;
            olast_reg <= cmd.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_kind      = kind_reg;
    assign out_dst_mac   = omac_reg;
    assign out_target_ip = oip_reg;
    assign out_tag       = otag_reg;
    assign out_last      = olast_reg;

    // status to the sequencer
    always_comb
    begin
        stat            = '0;
        stat.mode       = mode_reg;
        stat.scan_last  = (cnt_reg == LAST_IDX);
        stat.slot_ok    = found_reg || free_ok_reg;
        stat.ent_mapped = ent_mapped_reg;
        stat.ent_active = ent_active_reg;
        stat.ent_full   = (ent_count_reg >= HELD_MAX);
        stat.rel_done   = (k_reg == ent_count_reg);
        stat.rel_final  = ((k_reg + 1'b1) == ent_count_reg);
        stat.mac_ok     = mac_ok_reg;
        stat.is_ipv4    = ipv4_reg;
        stat.is_arp     = arp_reg;
        stat.tip_ok     = tip_ok_reg;
        stat.is_request = req_reg;
        stat.out_free   = !out_valid_reg || out_ready;
    end

endmodule

### design/arp_resolution_cache.sv
// Top level of the ARP resolution cache: sequencer plus datapath.
//
//  Channel  Signals                              Direction
//  in       in_valid/in_ready + event fields     event beat in
//  out      out_valid/out_ready + result fields  result beat out, out_last on final
//  cfg      cfg_valid/cfg_ready, cfg_index/data  register write, always ready
//
// One event at a time. A send scans the table with one entry compared per cycle,
// a receive also scans, then releases each held datagram through the queue RAM
// read port, a read state then an emit state per datagram, and a tick ages one
// entry per cycle. Reset clears all entries at once; no clearing pass.
// A stalled result register holds the sequencer.
module arp_resolution_cache #(
    parameter int TABLE_ENTRIES  = arc_pkg::TABLE_ENTRIES_DEF,
    parameter int HELD_PER_ENTRY = arc_pkg::HELD_PER_ENTRY_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   mode,
    input  logic [arc_pkg::IP_W-1:0]     next_hop_ip,
    input  logic [arc_pkg::TAG_W-1:0]    payload_tag,
    input  logic [arc_pkg::MAC_W-1:0]    frame_dst_mac,
    input  logic [15:0]                  frame_ethertype,
    input  logic [15:0]                  arp_opcode,
    input  logic [arc_pkg::IP_W-1:0]     arp_sender_ip,
    input  logic [arc_pkg::MAC_W-1:0]    arp_sender_mac,
    input  logic [arc_pkg::IP_W-1:0]     arp_target_ip,
    input  logic [15:0]                  elapsed_ms,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0]                   out_kind,
    output logic [arc_pkg::MAC_W-1:0]    out_dst_mac,
    output logic [arc_pkg::IP_W-1:0]     out_target_ip,
    output logic [arc_pkg::TAG_W-1:0]    out_tag,
    output logic                         out_last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [arc_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [arc_pkg::CFG_W-1:0]    cfg_data
);
    import arc_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    arc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    arc_dp #(
        .TABLE_ENTRIES  (TABLE_ENTRIES),
        .HELD_PER_ENTRY (HELD_PER_ENTRY)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mode            (mode),
        .next_hop_ip     (next_hop_ip),
        .payload_tag     (payload_tag),
        .frame_dst_mac   (frame_dst_mac),
        .frame_ethertype (frame_ethertype),
        .arp_opcode      (arp_opcode),
        .arp_sender_ip   (arp_sender_ip),
        .arp_sender_mac  (arp_sender_mac),
        .arp_target_ip   (arp_target_ip),
        .elapsed_ms      (elapsed_ms),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_kind        (out_kind),
        .out_dst_mac     (out_dst_mac),
        .out_target_ip   (out_target_ip),
        .out_tag         (out_tag),
        .out_last        (out_last)
    );

endmodule

### tb/sv/arp_resolution_cache_tb.sv
// Self-checking testbench for the ARP resolution cache.
`timescale 1ns / 100ps

module arp_resolution_cache_tb;
    import arc_pkg::*;

    localparam int NENT     = 16;
    localparam int NHELD    = 4;
    localparam int LIMIT    = 600000;
    localparam int SETTLE   = 60;
    localparam int PER_PHASE = 105;

    typedef struct {
        mode_t             m;
        logic [IP_W-1:0]   hop;
        logic [TAG_W-1:0]  tag;
        logic [MAC_W-1:0]  dmac;
        logic [15:0]       etype;
        logic [15:0]       op;
        logic [IP_W-1:0]   sip;
        logic [MAC_W-1:0]  smac;
        logic [IP_W-1:0]   tip;
        logic [15:0]       el;
    } arp_ev_t;

    typedef struct {
        kind_t             kind;
        logic [MAC_W-1:0]  mac;
        logic [IP_W-1:0]   ip;
        logic [TAG_W-1:0]  tag;
        logic              last;
    } arp_res_t;

    typedef struct {
        arp_ev_t  ev;
        bit       typed;
        arp_res_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] mode;
    logic [IP_W-1:0] next_hop_ip;
    logic [TAG_W-1:0] payload_tag;
    logic [MAC_W-1:0] frame_dst_mac;
    logic [15:0] frame_ethertype;
    logic [15:0] arp_opcode;
    logic [IP_W-1:0] arp_sender_ip;
    logic [MAC_W-1:0] arp_sender_mac;
    logic [IP_W-1:0] arp_target_ip;
    logic [15:0] elapsed_ms;
    logic out_valid;
    logic out_ready;
    logic [2:0] out_kind;
    logic [MAC_W-1:0] out_dst_mac;
    logic [IP_W-1:0] out_target_ip;
    logic [TAG_W-1:0] out_tag;
    logic out_last;
    logic cfg_valid;
    logic cfg_ready;
    logic [CIDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    arp_resolution_cache DUT (.*);

    // predictor copy of registers and table
    logic [MAC_W-1:0]  own_mac;
    logic [IP_W-1:0]   own_ip;
    logic [MS_W-1:0]   life_ms;
    logic [MS_W-1:0]   hold_ms;
    logic [TIME_W-1:0] clock_ms;
    logic              slot_used   [NENT];
    logic [IP_W-1:0]   slot_ip     [NENT];
    logic              slot_mapped [NENT];
    logic [MAC_W-1:0]  slot_mac    [NENT];
    logic [TIME_W-1:0] slot_learnt [NENT];
    logic              slot_asking [NENT];
    logic [TIME_W-1:0] slot_asked  [NENT];
    logic [TAG_W-1:0]  slot_held   [NENT][NHELD];
    int                slot_nheld  [NENT];

    arp_res_t pend[$];
    arp_res_t frames_due[$];
    logic [IP_W-1:0] hop_pool[20];

    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_off = 0;
    int cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void put(kind_t k, logic [MAC_W-1:0] mac, logic [IP_W-1:0] ip,
                                logic [TAG_W-1:0] tag);
        arp_res_t r;
        r.kind = k; r.mac = mac; r.ip = ip; r.tag = tag; r.last = 1'b0;
        pend.insert(pend.size(), r);
    endfunction

    function automatic int claim_slot(logic [IP_W-1:0] ip);
        for (int i = 0; i < NENT; i++)
            if (slot_used[i] && slot_ip[i] == ip)
                return i;
        for (int i = 0; i < NENT; i++)
            if (!slot_used[i])
            begin
                slot_used[i] = 1'b1;
                slot_ip[i] = ip;
                slot_mapped[i] = 1'b0;
                slot_asking[i] = 1'b0;
                slot_nheld[i] = 0;
                return i;
            end
        return -1;
    endfunction

    function automatic void resolve_send(logic [IP_W-1:0] ip, logic [TAG_W-1:0] tag);
        int e;
        e = claim_slot(ip);
        if (e < 0)
            put(KIND_DROP, '0, ip, tag);
        else if (slot_mapped[e])
            put(KIND_FWD, slot_mac[e], '0, tag);
        else
        begin
            if (!slot_asking[e])
            begin
                put(KIND_REQ, MAC_BCAST, ip, '0);
                slot_asking[e] = 1'b1;
                slot_asked[e] = clock_ms;
            end
            if (slot_nheld[e] < NHELD)
            begin
                slot_held[e][slot_nheld[e]] = tag;
                slot_nheld[e]++;
            end
            else
                put(KIND_DROP, '0, ip, tag);
        end
    endfunction

    function automatic void resolve_recv(arp_ev_t ev);
        int e;
        if (ev.dmac != own_mac && ev.dmac != MAC_BCAST)
            return;
        if (ev.etype == ETYPE_IPV4)
        begin
            put(KIND_UP, '0, '0, ev.tag);
            return;
        end
        if (ev.etype != ETYPE_ARP)
        begin
            put(KIND_BAD, '0, '0, '0);
            return;
        end
        if (ev.tip != own_ip)
            return;
        e = claim_slot(ev.sip);
        if (e >= 0 && !slot_mapped[e])
        begin
            slot_mapped[e] = 1'b1;
            slot_mac[e] = ev.smac;
            slot_learnt[e] = clock_ms;
            for (int k = 0; k < slot_nheld[e]; k++)
                put(KIND_FWD, ev.smac, '0, slot_held[e][k]);
            slot_nheld[e] = 0;
        end
        if (ev.op == OP_REQUEST)
            put(KIND_REPLY, ev.smac, ev.sip, '0);
    endfunction

    function automatic void age_table(logic [15:0] el);
        clock_ms += TIME_W'(el);
        for (int i = 0; i < NENT; i++)
        begin
            if (!slot_used[i])
                continue;
            if (slot_mapped[i] && clock_ms - slot_learnt[i] >= TIME_W'(life_ms))
                slot_mapped[i] = 1'b0;
            if (slot_asking[i] && clock_ms - slot_asked[i] >= TIME_W'(hold_ms))
                slot_asking[i] = 1'b0;
            if (!slot_mapped[i] && !slot_asking[i] && slot_nheld[i] == 0)
                slot_used[i] = 1'b0;
        end
    endfunction

    // work out the results of one event into pend
    function automatic void resolve_event(arp_ev_t ev);
        pend.delete();
        case (ev.m)
            MODE_SEND: resolve_send(ev.hop, ev.tag);
            MODE_RECV: resolve_recv(ev);
            MODE_TICK: age_table(ev.el);
            default: ;
        endcase
        if (pend.size() > 0)
            pend[pend.size()-1].last = 1'b1;
    endfunction

    function automatic arp_ev_t noise_ev();
        arp_ev_t ev;
        ev.m = mode_t'($urandom_range(3));
        ev.hop = $urandom;
        ev.tag = 16'($urandom);
        ev.dmac = MAC_W'({$urandom, $urandom});
        ev.etype = 16'($urandom);
        ev.op = 16'($urandom);
        ev.sip = $urandom;
        ev.smac = MAC_W'({$urandom, $urandom});
        ev.tip = $urandom;
        ev.el = 16'($urandom);
        return ev;
    endfunction

    function automatic arp_ev_t mk_send(logic [IP_W-1:0] ip, logic [TAG_W-1:0] tag);
        arp_ev_t ev;
        ev = noise_ev();
        ev.m = MODE_SEND; ev.hop = ip; ev.tag = tag;
        return ev;
    endfunction

    function automatic arp_ev_t mk_recv(logic [MAC_W-1:0] dmac, logic [15:0] etype,
                                        logic [15:0] op, logic [IP_W-1:0] sip,
                                        logic [MAC_W-1:0] smac, logic [IP_W-1:0] tip);
        arp_ev_t ev;
        ev = noise_ev();
        ev.m = MODE_RECV; ev.dmac = dmac; ev.etype = etype;
        ev.op = op; ev.sip = sip; ev.smac = smac; ev.tip = tip;
        return ev;
    endfunction

    function automatic arp_ev_t mk_tick(logic [15:0] el);
        arp_ev_t ev;
        ev = noise_ev();
        ev.m = MODE_TICK; ev.el = el;
        return ev;
    endfunction

    // mostly well-formed traffic over a small address pool, so the table fills
    function automatic arp_ev_t random_ev();
        arp_ev_t ev;
        int r;
        int sub;
        logic [MAC_W-1:0] dst;
        r = $urandom_range(99);
        sub = $urandom_range(9);
        case ($urandom_range(5))
            0, 1, 2, 3: dst = own_mac;
            4: dst = MAC_BCAST;
            default: dst = MAC_W'({$urandom, $urandom});
        endcase
        if (r < 40)
            ev = mk_send(($urandom_range(9) == 0) ? $urandom : hop_pool[$urandom_range(19)],
                         16'($urandom));
        else if (r < 80)
        begin
            if (sub < 7)
                ev = mk_recv(dst, ETYPE_ARP,
                             ($urandom_range(7) == 0) ? 16'($urandom) :
                                 16'($urandom_range(1, 2)),
                             hop_pool[$urandom_range(19)], MAC_W'({$urandom, $urandom}),
                             ($urandom_range(6) == 0) ? $urandom : own_ip);
            else if (sub == 7)
                ev = mk_recv(dst, ETYPE_IPV4, 16'($urandom), $urandom,
                             MAC_W'({$urandom, $urandom}), $urandom);
            else if (sub == 8)
                ev = mk_recv(dst, 16'($urandom), 16'($urandom), $urandom,
                             MAC_W'({$urandom, $urandom}), $urandom);
            else
                ev = noise_ev();
        end
        else if (r < 95)
            ev = mk_tick(($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(120)));
        else
        begin
            ev = noise_ev();
            ev.m = MODE_NOP;
        end
        return ev;
    endfunction

    task automatic offer_event(arp_ev_t ev, bit typed, arp_res_t want);
        bit ok;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= ev.m;
        next_hop_ip <= ev.hop;
        payload_tag <= ev.tag;
        frame_dst_mac <= ev.dmac;
        frame_ethertype <= ev.etype;
        arp_opcode <= ev.op;
        arp_sender_ip <= ev.sip;
        arp_sender_mac <= ev.smac;
        arp_target_ip <= ev.tip;
        elapsed_ms <= ev.el;
        do
        begin
            @(negedge clk);
            ok = in_ready;
            @(posedge clk);
        end
        while (!ok);
        resolve_event(ev);
        if (typed)
        begin
            pend.delete();
            pend.insert(0, want);
        end
        foreach (pend[i])
            frames_due.insert(frames_due.size(), pend[i]);
        n_items++;
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
        bit ok;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
        begin
            @(negedge clk);
            ok = cfg_ready;
            @(posedge clk);
        end
        while (!ok);
        case (idx)
            REG_LOCAL_MAC: own_mac = val[MAC_W-1:0];
            REG_LOCAL_IP:  own_ip = val[IP_W-1:0];
            REG_TIMEOUT:   life_ms = val[MS_W-1:0];
            REG_HOLD:      hold_ms = val[MS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [MAC_W-1:0] mac, logic [IP_W-1:0] ip,
                            logic [MS_W-1:0] life, logic [MS_W-1:0] hold);
        write_reg(REG_LOCAL_MAC, CFG_W'(mac));
        write_reg(REG_LOCAL_IP, CFG_W'(ip));
        write_reg(REG_TIMEOUT, CFG_W'(life));
        write_reg(REG_HOLD, CFG_W'(hold));
        cfg_valid <= 1'b0;
        for (int i = 0; i < 20; i++)
            hop_pool[i] = (i == 0) ? ip : $urandom;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (frames_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                out_ready <= 1'b0;
                hold_off--;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            arp_res_t w;
            n_results++;
            if (frames_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result kind=%0d mac=%h ip=%h tag=%h last=%b",
                         $time, out_kind, out_dst_mac, out_target_ip, out_tag, out_last);
            end
            else
            begin
                w = frames_due[0];
                frames_due.delete(0);
                if (out_kind !== w.kind || out_dst_mac !== w.mac ||
                    out_target_ip !== w.ip || out_tag !== w.tag || out_last !== w.last)
                begin
                    errors++;
                    $display("%0t: mismatch expected kind=%0d mac=%h ip=%h tag=%h last=%b",
                             $time, w.kind, w.mac, w.ip, w.tag, w.last);
                    $display("%0t:          actual   kind=%0d mac=%h ip=%h tag=%h last=%b",
                             $time, out_kind, out_dst_mac, out_target_ip, out_tag,
                             out_last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results pending", cycles,
                     frames_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        dir_row_t rows[$];
        dir_row_t row;
        arp_res_t none;
        logic [MAC_W-1:0] lmac;
        logic [IP_W-1:0] lip;
        logic [IP_W-1:0] hop_a;
        int idle_set[4];
        int stall_set[4];

        rst_n = 1'b0;
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        mode <= MODE_NOP;
        next_hop_ip <= '0;
        payload_tag <= '0;
        frame_dst_mac <= '0;
        frame_ethertype <= '0;
        arp_opcode <= '0;
        arp_sender_ip <= '0;
        arp_sender_mac <= '0;
        arp_target_ip <= '0;
        elapsed_ms <= '0;
        own_mac = '0; own_ip = '0; life_ms = TIMEOUT_RST; hold_ms = HOLD_RST;
        clock_ms = '0;
        for (int i = 0; i < NENT; i++)
        begin
            slot_used[i] = 1'b0; slot_mapped[i] = 1'b0; slot_asking[i] = 1'b0;
            slot_nheld[i] = 0;
        end
        none = '{KIND_FWD, '0, '0, '0, 1'b0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        lmac = 48'h02_1a_2b_3c_4d_5e;
        lip = 32'hc0a8_0001;
        hop_a = 32'h0a00_0005;
        set_regs(lmac, lip, TIMEOUT_RST, HOLD_RST);

        row.typed = 1'b0; row.want = none;
        row.ev = mk_recv(lmac, ETYPE_IPV4, '0, '0, '0, '0); row.ev.tag = 16'hffff;
        row.typed = 1'b1; row.want = '{KIND_UP, '0, '0, 16'hffff, 1'b1};
        rows.insert(rows.size(), row);
        row.ev = mk_recv(MAC_BCAST, 16'hffff, '0, '0, '0, '0);
        row.want = '{KIND_BAD, '0, '0, '0, 1'b1}; rows.insert(rows.size(), row);
        row.ev = mk_recv(MAC_BCAST, 16'h0000, '0, '0, '0, '0); rows.insert(rows.size(), row);
        row.typed = 1'b0;
        row.ev = mk_recv('0, ETYPE_IPV4, '0, '0, '0, '0); rows.insert(rows.size(), row);
        row.typed = 1'b1;
        row.ev = mk_send(hop_a, 16'd1);
        row.want = '{KIND_REQ, MAC_BCAST, hop_a, '0, 1'b1}; rows.insert(rows.size(), row);
        row.typed = 1'b0;
        for (int t = 2; t <= 4; t++)
        begin
            row.ev = mk_send(hop_a, 16'(t)); rows.insert(rows.size(), row);
        end
        // hold queue is full now
        row.typed = 1'b1;
        row.ev = mk_send(hop_a, 16'd5);
        row.want = '{KIND_DROP, '0, hop_a, 16'd5, 1'b1}; rows.insert(rows.size(), row);
        row.typed = 1'b0;
        row.ev = mk_recv(lmac, ETYPE_ARP, 16'd2, hop_a, MAC_BCAST, lip);
        rows.insert(rows.size(), row);
        row.typed = 1'b1;
        row.ev = mk_send(hop_a, 16'h0000);
        row.want = '{KIND_FWD, MAC_BCAST, '0, 16'h0000, 1'b1};
        rows.insert(rows.size(), row);
        row.typed = 1'b0;
        row.ev = mk_recv(MAC_BCAST, ETYPE_ARP, OP_REQUEST, 32'hffff_ffff, '0, lip);
        rows.insert(rows.size(), row);
        row.ev = mk_recv(MAC_BCAST, ETYPE_ARP, OP_REQUEST, 32'h0a00_0009, 48'h1, ~lip);
        rows.insert(rows.size(), row);
        row.ev = mk_recv(lmac, ETYPE_ARP, 16'hffff, '0, 48'h1234_5678_9abc, lip);
        rows.insert(rows.size(), row);
        row.ev = mk_send('0, 16'd7); rows.insert(rows.size(), row);
        row.ev = mk_recv(lmac, ETYPE_ARP, OP_REQUEST, hop_a, 48'h0a0b_0c0d_0e0f, lip);
        rows.insert(rows.size(), row);
        row.ev = mk_tick(16'hffff); rows.insert(rows.size(), row);
        row.ev = mk_tick(16'h0000); rows.insert(rows.size(), row);
        row.ev = noise_ev(); row.ev.m = MODE_NOP; rows.insert(rows.size(), row);
        row.ev = mk_send(32'hffff_ffff, 16'habcd); rows.insert(rows.size(), row);
        row.ev = mk_send(hop_a, 16'h1111); rows.insert(rows.size(), row);

        foreach (rows[i])
            offer_event(rows[i].ev, rows[i].typed, rows[i].want);
        drain();

        idle_set = '{0, 73, 0, 38};
        stall_set = '{0, 0, 73, 38};
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_regs(MAC_W'({$urandom, $urandom}), $urandom, 200, 50);
                1: set_regs('0, '0, 1, 1);
                2: set_regs(MAC_BCAST, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
                default: set_regs(MAC_W'({$urandom, $urandom}), $urandom, 1000, 300);
            endcase
            idle_pct = idle_set[ph];
            stall_pct = stall_set[ph];
            // long receiver hold-off while events keep coming
            if (ph == 0)
                hold_off = 400;
            for (int k = 0; k < PER_PHASE; k++)
                offer_event(random_ev(), 1'b0, none);
            drain();
        end

        $display("Covered %0d events and %0d result beats in four idle/stall phases,",
                 n_items, n_results);
        $display("with table fill, queue overflow, expiry and register extremes.");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
